// ===== hdl/dpb_pkg.sv =====
// Shared types, register map and reset values for the depth pixel backprojector.
// No dependencies; imported by the top level, front and back, and used by the checker.
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int XY_W      = 20;
    localparam int Z_W       = 16;
    localparam int COLOR_W   = 8;
    localparam int RECIP_W   = 24;
    localparam int FRAC_SHIFT = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_STEP     = 4'd0,
        REG_FRAME_PERIOD  = 4'd1,
        REG_NEAR_LIMIT    = 4'd2,
        REG_FAR_LIMIT     = 4'd3,
        REG_CENTER_COL    = 4'd4,
        REG_CENTER_ROW    = 4'd5,
        REG_RECIP_FOCAL_X = 4'd6,
        REG_RECIP_FOCAL_Y = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]          grid_step;
        logic [7:0]          frame_period;
        logic [15:0]         near_limit;
        logic [15:0]         far_limit;
        logic [15:0]         center_col;
        logic [15:0]         center_row;
        logic [RECIP_W-1:0]  recip_focal_x;
        logic [RECIP_W-1:0]  recip_focal_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        grid_step:     5'd4,
        frame_period:  8'd1,
        near_limit:    16'd150,
        far_limit:     16'd1500,
        center_col:    16'd5120,
        center_row:    16'd3840,
        recip_focal_x: 24'd27962,
        recip_focal_y: 24'd27962
    };

    // signed width of 16*coord - center
    function automatic int du_width(input int coord_bits);
        return ((coord_bits + 4 > 16) ? coord_bits + 4 : 16) + 1;
    endfunction

    function automatic int item_width(input int coord_bits, input int depth_bits);
        return 2 * du_width(coord_bits) + depth_bits + 3 * COLOR_W;
    endfunction

endpackage

// ===== hdl/depth_pixel_backprojector_core.sv =====
// Top level of the depth pixel backprojector: configuration registers, front, queue, back.
// Depends on dpb_pkg, dpb_front, dpb_queue and dpb_back.
//
// Usage:
//   Pixel channel: i_valid with the depth/color/raster-marker fields; a transaction
//   completes on a rising edge with i_valid high and o_stall low. Pixels come in
//   raster order; i_row_end marks the last pixel of a row, i_frame_end the last of
//   a frame. Pixels off the stride grid, in skipped frames, with invalid depth or
//   outside [near_limit, far_limit] produce no point.
//   Point channel: o_valid with pos_x/pos_y/pos_z and color; a transaction completes
//   with o_valid high and i_stall low. Results keep pixel order.
//   Configuration: i_cfg_valid/o_cfg_ready with a register index and data; ready is
//   always high. Indexes beyond the register list are ignored.
//   Throughput: one pixel per cycle while o_stall is low. A kept pixel reaches o_valid
//   through the queue read with abs, two multiply stages, the sum and the output
//   register.
//   Stall: i_stall freezes the five-stage projection pipeline while o_valid is high;
//   the front keeps taking pixels into the four-entry queue, raising o_stall only when full.
//   Reset: synchronous, active low; clears counters, phases, queue and pipeline
//   valids and loads the register defaults. No clearing pass.
`timescale 1ns / 1ps

module depth_pixel_backprojector_core #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [DEPTH_BITS-1:0]               i_depth_mm,
    input  logic                                i_depth_ok,
    input  logic [7:0]                          i_blue_in,
    input  logic [7:0]                          i_green_in,
    input  logic [7:0]                          i_red_in,
    input  logic                                i_row_end,
    input  logic                                i_frame_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dpb_pkg::XY_W-1:0]     o_pos_x,
    output logic signed [dpb_pkg::XY_W-1:0]     o_pos_y,
    output logic [dpb_pkg::Z_W-1:0]             o_pos_z,
    output logic [7:0]                          o_blue_out,
    output logic [7:0]                          o_green_out,
    output logic [7:0]                          o_red_out
);

    import dpb_pkg::*;

    localparam int ITEM_W = item_width(COORD_BITS, DEPTH_BITS);

    t_cfg              r_cfg;
    logic              w_accept;
    logic              w_push;
    logic [ITEM_W-1:0] w_push_item;
    logic              w_full;
    logic              w_q_valid;
    logic [ITEM_W-1:0] w_q_item;
    logic              w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;
    assign w_accept    = i_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRID_STEP:     r_cfg.grid_step     <= i_cfg_data[4:0];
                REG_FRAME_PERIOD:  r_cfg.frame_period  <= i_cfg_data[7:0];
                REG_NEAR_LIMIT:    r_cfg.near_limit    <= i_cfg_data[15:0];
                REG_FAR_LIMIT:     r_cfg.far_limit     <= i_cfg_data[15:0];
                REG_CENTER_COL:    r_cfg.center_col    <= i_cfg_data[15:0];
                REG_CENTER_ROW:    r_cfg.center_row    <= i_cfg_data[15:0];
                REG_RECIP_FOCAL_X: r_cfg.recip_focal_x <= i_cfg_data[RECIP_W-1:0];
                REG_RECIP_FOCAL_Y: r_cfg.recip_focal_y <= i_cfg_data[RECIP_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    dpb_front #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_depth_mm  (i_depth_mm),
        .i_depth_ok  (i_depth_ok),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_row_end   (i_row_end),
        .i_frame_end (i_frame_end),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    dpb_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_item)
    );

    dpb_back #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out)
    );

endmodule

// ===== hdl/dpb_queue.sv =====
// Small register FIFO between the front classifier and the projection pipeline.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps

module dpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/dpb_front.sv =====
// Front end: raster counters, stride/frame/depth filtering, principal point offset.
// Depends on dpb_pkg; feeds dpb_queue.
`timescale 1ns / 1ps

module dpb_front #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF,
    parameter int ITEM_W     = dpb_pkg::item_width(COORD_BITS, DEPTH_BITS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpb_pkg::t_cfg         i_cfg,
    input  logic                  i_accept,
    input  logic [DEPTH_BITS-1:0] i_depth_mm,
    input  logic                  i_depth_ok,
    input  logic [7:0]            i_blue_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_red_in,
    input  logic                  i_row_end,
    input  logic                  i_frame_end,
    output logic                  o_push,
    output logic [ITEM_W-1:0]     o_item
);

    import dpb_pkg::*;

    localparam int DU_W  = du_width(COORD_BITS);
    localparam int CMP_W = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;

    typedef struct packed {
        logic signed [DU_W-1:0] du_x;
        logic signed [DU_W-1:0] du_y;
        logic [DEPTH_BITS-1:0]  z;
        logic [7:0]             blue;
        logic [7:0]             green;
        logic [7:0]             red;
    } t_item;

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [3:0]            r_col_ph;
    logic [3:0]            r_row_ph;
    logic [7:0]            r_frame_ph;

    logic [4:0]  w_step;
    logic [4:0]  w_col_inc;
    logic [4:0]  w_row_inc;
    logic [8:0]  w_frame_inc;
    logic [3:0]  n_col_ph;
    logic [3:0]  n_row_ph;
    logic [7:0]  n_frame_ph;
    logic        w_frame_on;
    logic        w_in_range;
    logic        w_keep;
    logic [DU_W-1:0] w_ucol;
    logic [DU_W-1:0] w_urow;
    t_item       w_item;

    always_comb begin
        if (i_cfg.grid_step == 5'd0) begin
            w_step = 5'd1;
        end else if (i_cfg.grid_step > 5'd16) begin
            w_step = 5'd16;
        end else begin
            w_step = i_cfg.grid_step;
        end
    end

    assign w_col_inc   = {1'b0, r_col_ph} + 5'd1;
    assign w_row_inc   = {1'b0, r_row_ph} + 5'd1;
    assign w_frame_inc = {1'b0, r_frame_ph} + 9'd1;
    assign n_col_ph    = (w_col_inc >= w_step) ? 4'd0 : w_col_inc[3:0];
    assign n_row_ph    = (w_row_inc >= w_step) ? 4'd0 : w_row_inc[3:0];
    assign n_frame_ph  = (w_frame_inc >= {1'b0, i_cfg.frame_period}) ? 8'd0
                                                                     : w_frame_inc[7:0];

    assign w_frame_on = (i_cfg.frame_period <= 8'd1) || (r_frame_ph == 8'd0);
    assign w_in_range = (CMP_W'(i_depth_mm) >= CMP_W'(i_cfg.near_limit)) &&
                        (CMP_W'(i_depth_mm) <= CMP_W'(i_cfg.far_limit));
    assign w_keep     = w_frame_on && (r_col_ph == 4'd0) && (r_row_ph == 4'd0) &&
                        i_depth_ok && w_in_range;

    assign w_ucol = DU_W'({r_col, 4'b0000});
    assign w_urow = DU_W'({r_row, 4'b0000});

    assign w_item.du_x  = signed'(w_ucol - DU_W'(i_cfg.center_col));
    assign w_item.du_y  = signed'(w_urow - DU_W'(i_cfg.center_row));
    assign w_item.z     = i_depth_mm;
    assign w_item.blue  = i_blue_in;
    assign w_item.green = i_green_in;
    assign w_item.red   = i_red_in;

    assign o_push = i_accept && w_keep;
    assign o_item = w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_ph   <= '0;
            r_row_ph   <= '0;
            r_frame_ph <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_col    <= '0;
                r_row    <= '0;
                r_col_ph <= '0;
                r_row_ph <= '0;
                if (i_cfg.frame_period > 8'd1) begin
                    r_frame_ph <= n_frame_ph;
                end
            end else if (i_row_end) begin
                r_col    <= '0;
                r_col_ph <= '0;
                r_row    <= r_row + 1'b1;
                r_row_ph <= n_row_ph;
            end else begin
                r_col    <= r_col + 1'b1;
                r_col_ph <= n_col_ph;
            end
        end
    end

endmodule

// ===== hdl/dpb_back.sv =====
// Back end: pinhole projection pipeline with rounding, saturation and output register.
// Depends on dpb_pkg; drains dpb_queue.
`timescale 1ns / 1ps

module dpb_back #(
    parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF,
    parameter int ITEM_W     = dpb_pkg::item_width(COORD_BITS, DEPTH_BITS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dpb_pkg::t_cfg                      i_cfg,
    input  logic                               i_q_valid,
    input  logic [ITEM_W-1:0]                  i_q_item,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [dpb_pkg::XY_W-1:0]    o_pos_x,
    output logic signed [dpb_pkg::XY_W-1:0]    o_pos_y,
    output logic [dpb_pkg::Z_W-1:0]            o_pos_z,
    output logic [7:0]                         o_blue_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_red_out
);

    import dpb_pkg::*;

    localparam int DU_W  = du_width(COORD_BITS);
    localparam int MAG_W = DU_W - 1;
    localparam int A_W   = MAG_W + RECIP_W;
    localparam int AH_W  = A_W - RECIP_W;
    localparam int PL_W  = RECIP_W + DEPTH_BITS;
    localparam int PH_W  = AH_W + DEPTH_BITS;
    localparam int PR_W  = A_W + DEPTH_BITS + 1;
    localparam int RW    = PR_W - FRAC_SHIFT;
    localparam logic [RW-1:0] POS_MAX = RW'((1 << (XY_W - 1)) - 1);
    localparam logic [RW-1:0] NEG_MAX = RW'(1 << (XY_W - 1));

    typedef struct packed {
        logic signed [DU_W-1:0] du_x;
        logic signed [DU_W-1:0] du_y;
        logic [DEPTH_BITS-1:0]  z;
        logic [7:0]             blue;
        logic [7:0]             green;
        logic [7:0]             red;
    } t_item;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] z;
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
    } t_side;

    t_item w_item;
    logic  w_en;

    logic [RECIP_W-1:0] w_recip [2];
    logic signed [DU_W-1:0] w_du [2];

    logic       r_v1, r_v2, r_v3, r_v4, r_out_valid;
    t_side      r_s1, r_s2, r_s3, r_s4;
    logic [1:0] r_neg1, r_neg2, r_neg3, r_neg4;
    logic [MAG_W-1:0] r_mag [2];
    logic [A_W-1:0]   r_a   [2];
    logic [PL_W-1:0]  r_pl  [2];
    logic [PH_W-1:0]  r_ph  [2];
    logic [PR_W-1:0]  r_pr  [2];
    logic [XY_W-1:0]  r_xy  [2];
    logic [DEPTH_BITS-1:0] r_z_out;
    logic [7:0]       r_b_out, r_g_out, r_r_out;

    logic [RW-1:0]   w_r   [2];
    logic [XY_W-1:0] n_xy  [2];

    assign w_item     = i_q_item;
    assign w_en       = !r_out_valid || !i_stall;
    assign o_pop      = w_en && i_q_valid;
    assign w_recip[0] = i_cfg.recip_focal_x;
    assign w_recip[1] = i_cfg.recip_focal_y;
    assign w_du[0]    = w_item.du_x;
    assign w_du[1]    = w_item.du_y;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_r[k] = r_pr[k][PR_W-1:FRAC_SHIFT];
            if (r_neg4[k]) begin
                n_xy[k] = (w_r[k] > NEG_MAX) ? XY_W'(NEG_MAX) : XY_W'(-w_r[k]);
            end else begin
                n_xy[k] = (w_r[k] > POS_MAX) ? XY_W'(POS_MAX) : w_r[k][XY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= '{z: w_item.z, blue: w_item.blue, green: w_item.green, red: w_item.red};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_neg2 <= r_neg1;
            r_neg3 <= r_neg2;
            r_neg4 <= r_neg3;
            for (int k = 0; k < 2; k++) begin
                r_neg1[k] <= w_du[k][DU_W-1];
                r_mag[k]  <= w_du[k][DU_W-1] ? MAG_W'(-w_du[k]) : MAG_W'(w_du[k]);
                r_a[k]    <= A_W'(r_mag[k]) * A_W'(w_recip[k]);
                r_pl[k]   <= PL_W'(r_a[k][RECIP_W-1:0]) * PL_W'(r_s2.z);
                r_ph[k]   <= PH_W'(r_a[k][A_W-1:RECIP_W]) * PH_W'(r_s2.z);
                r_pr[k]   <= (PR_W'(r_ph[k]) << RECIP_W) + PR_W'(r_pl[k]) +
                             (PR_W'(1) << (FRAC_SHIFT - 1));
                r_xy[k]   <= n_xy[k];
            end
            r_z_out <= r_s4.z;
            r_b_out <= r_s4.blue;
            r_g_out <= r_s4.green;
            r_r_out <= r_s4.red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_q_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = signed'(r_xy[0]);
    assign o_pos_y     = signed'(r_xy[1]);
    assign o_pos_z     = Z_W'(r_z_out);
    assign o_blue_out  = r_b_out;
    assign o_green_out = r_g_out;
    assign o_red_out   = r_r_out;

endmodule

// ===== hdl/dpb_checker.sv =====
// Port-level assertions for depth_pixel_backprojector_core, attached by bind.
// Depends on dpb_pkg and the top level's port list.
`timescale 1ns / 1ps

module dpb_checker #(
    parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic signed [dpb_pkg::XY_W-1:0] o_pos_x,
    input logic signed [dpb_pkg::XY_W-1:0] o_pos_y,
    input logic [dpb_pkg::Z_W-1:0]         o_pos_z
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_zero_depth_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DEPTH_BITS <= 16) && o_valid && (o_pos_z == '0) |->
            (o_pos_x == '0) && (o_pos_y == '0))
        else $error("point at zero depth off the optical axis");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("point transaction dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_pos_z))
        else $error("stalled point changed");

endmodule

bind depth_pixel_backprojector_core dpb_checker #(
    .DEPTH_BITS (DEPTH_BITS)
) u_dpb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pos_x (o_pos_x),
    .o_pos_y (o_pos_y),
    .o_pos_z (o_pos_z)
);
